@@ hdl/wbrc_pkg.sv @@
// ----------------------------------------------------------------------------
// wbrc_pkg
// shared types and codes for the write-back register cache
// ----------------------------------------------------------------------------
package wbrc_pkg;

    localparam int GUEST_REGS = 32;
    localparam int GUEST_W    = 5;
    localparam int HOST_W     = 6;
    localparam int DATA_W     = 32;

    localparam logic [DATA_W-1:0] SMALL_IMM_MAX = 32'h0000_7FFF;

    typedef enum logic [2:0] {
        OP_READ          = 3'd0,
        OP_WRITE         = 3'd1,
        OP_SET_IMM       = 3'd2,
        OP_QUERY         = 3'd3,
        OP_FLUSH_ALL     = 3'd4,
        OP_FLUSH_DISCARD = 3'd5,
        OP_FLUSH_ONE     = 3'd6,
        OP_RESET         = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        ACT_NONE     = 3'd0,
        ACT_LOAD     = 3'd1,
        ACT_IMM_LOW  = 3'd2,
        ACT_IMM_FULL = 3'd3,
        ACT_STORE    = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FILL,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        op_t                  op;
        logic [GUEST_W-1:0]   guest;
        logic [DATA_W-1:0]    value;
        logic [GUEST_REGS-1:0] discard;
    } cmd_t;

endpackage

@@ hdl/write_back_register_cache.sv @@
// a request is accepted into the command queue whenever the queue is not full; the
// sequencer pops it when idle and registers its first result on m_*
// a miss with no free or clean slot first stores slot 0, then fills slot 0; a flush emits
// one store per flushed slot (at least one result); the sequencer handles one request at a time
// reset: all slots invalid and clean, known mask clear, queue empty; known
// constants are not cleared and hold garbage until set
// ----------------------------------------------------------------------------
// write_back_register_cache
// fully associative write-back cache of guest registers in host slots
// ----------------------------------------------------------------------------
module write_back_register_cache
    import wbrc_pkg::*;
#(
    parameter int SLOTS      = 8,
    parameter int FIRST_HOST = 0
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [2:0]            s_mode,
    input  logic [GUEST_W-1:0]    s_guest_reg,
    input  logic [DATA_W-1:0]     s_value,
    input  logic [GUEST_REGS-1:0] s_discard_mask,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [2:0]            m_action,
    output logic [HOST_W-1:0]     m_host_reg,
    output logic [GUEST_W-1:0]    m_guest_reg_out,
    output logic [DATA_W-1:0]     m_value_out,
    output logic                  m_known,
    output logic                  m_last
);

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_valid;
    cmd_t push_cmd;
    cmd_t head_cmd;

    wbrc_front u_front (
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_guest_reg    (s_guest_reg),
        .s_value        (s_value),
        .s_discard_mask (s_discard_mask),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_cmd          (push_cmd)
    );

    wbrc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (head_cmd)
    );

    wbrc_back #(
        .SLOTS      (SLOTS),
        .FIRST_HOST (FIRST_HOST)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .q_head          (head_cmd),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_action        (m_action),
        .m_host_reg      (m_host_reg),
        .m_guest_reg_out (m_guest_reg_out),
        .m_value_out     (m_value_out),
        .m_known         (m_known),
        .m_last          (m_last)
    );

endmodule

@@ hdl/wbrc_front.sv @@
// ----------------------------------------------------------------------------
// wbrc_front
// accepts requests and classifies them into commands for the queue
// ----------------------------------------------------------------------------
module wbrc_front
    import wbrc_pkg::*;
(
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [2:0]            s_mode,
    input  logic [GUEST_W-1:0]    s_guest_reg,
    input  logic [DATA_W-1:0]     s_value,
    input  logic [GUEST_REGS-1:0] s_discard_mask,
    input  logic                  q_full,
    output logic                  q_push,
    output cmd_t                  q_cmd
);

    op_t op;

    always_comb begin
        unique case (s_mode)
            3'd0:    op = OP_READ;
            3'd1:    op = OP_WRITE;
            3'd2:    op = OP_SET_IMM;
            3'd3:    op = OP_QUERY;
            3'd4:    op = OP_FLUSH_ALL;
            3'd5:    op = OP_FLUSH_DISCARD;
            3'd6:    op = OP_FLUSH_ONE;
            default: op = OP_RESET;
        endcase
    end

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        q_cmd.op      = op;
        q_cmd.guest   = s_guest_reg;
        q_cmd.value   = s_value;
        // only a discarding flush carries a mask of dirty registers to drop
        q_cmd.discard = (op == OP_FLUSH_DISCARD) ? s_discard_mask : '0;
    end

endmodule

@@ hdl/wbrc_queue.sv @@
// ----------------------------------------------------------------------------
// wbrc_queue
// two-entry command queue between front and back
// ----------------------------------------------------------------------------
module wbrc_queue
    import wbrc_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_cmd
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ hdl/wbrc_back.sv @@
// ----------------------------------------------------------------------------
// wbrc_back
// slot tags, known constants and the sequencer that emits actions
// ----------------------------------------------------------------------------
module wbrc_back
    import wbrc_pkg::*;
#(
    parameter int SLOTS      = 8,
    parameter int FIRST_HOST = 0
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  cmd_t                q_head,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [2:0]          m_action,
    output logic [HOST_W-1:0]   m_host_reg,
    output logic [GUEST_W-1:0]  m_guest_reg_out,
    output logic [DATA_W-1:0]   m_value_out,
    output logic                m_known,
    output logic                m_last
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    state_t state_reg, state_next;
    cmd_t   cmd_reg;

    logic [GUEST_W-1:0]    slot_guest_reg [SLOTS];
    logic [SLOTS-1:0]      slot_valid_reg;
    logic [SLOTS-1:0]      slot_dirty_reg;
    logic [SLOTS-1:0]      store_vec_reg;
    logic [GUEST_REGS-1:0] known_bits_reg;
    logic [DATA_W-1:0]     known_mem [GUEST_REGS];
    logic [DATA_W-1:0]     rd_data_reg;

    logic                  out_valid_reg;
    action_t               out_action_reg;
    logic [HOST_W-1:0]     out_host_reg;
    logic [GUEST_W-1:0]    out_guest_reg;
    logic [DATA_W-1:0]     out_value_reg;
    logic                  out_known_reg;
    logic                  out_last_reg;

    logic [SLOTS-1:0] hit_vec;
    logic [SLOTS-1:0] flush_vec;
    logic [SLOTS-1:0] dirty_hit_vec;
    logic [SLOTS-1:0] store_rest;
    logic             hit;
    logic             any_inv;
    logic             any_clean;
    logic             need_evict;
    logic             can_emit;
    logic             is_known;
    logic [SW-1:0]    hit_idx;
    logic [SW-1:0]    choose_idx;
    logic [SW-1:0]    dirty_hit_idx;
    logic [SW-1:0]    st_idx;
    action_t          load_action;
    logic [DATA_W-1:0] load_value;

    // sequencer strobes
    logic              emit;
    action_t           e_action;
    logic [HOST_W-1:0] e_host;
    logic [GUEST_W-1:0] e_guest;
    logic [DATA_W-1:0] e_value;
    logic              e_known;
    logic              e_last;
    logic              fill_en;
    logic [SW-1:0]     fill_slot;
    logic              fill_dirty;
    logic              mark_en;
    logic              clean_en;
    logic              set_known;
    logic              clr_known;
    logic              mem_we;
    logic              reset_all;
    logic              flush_start;
    logic              store_clr;

    function automatic logic [SW-1:0] first_idx(input logic [SLOTS-1:0] v);
        logic [SW-1:0] idx;
        idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = SW'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic [HOST_W-1:0] host_of(input logic [SW-1:0] slot);
        return HOST_W'(FIRST_HOST + int'(slot));
    endfunction

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            hit_vec[i]   = slot_valid_reg[i] && (slot_guest_reg[i] == cmd_reg.guest);
            flush_vec[i] = slot_valid_reg[i] && slot_dirty_reg[i]
                           && !cmd_reg.discard[slot_guest_reg[i]];
        end
    end

    assign dirty_hit_vec = hit_vec & slot_dirty_reg;
    assign hit           = |hit_vec;
    assign any_inv       = |(~slot_valid_reg);
    assign any_clean     = |(~slot_dirty_reg);
    assign hit_idx       = first_idx(hit_vec);
    assign dirty_hit_idx = first_idx(dirty_hit_vec);
    assign choose_idx    = any_inv ? first_idx(~slot_valid_reg) : first_idx(~slot_dirty_reg);
    assign need_evict    = !hit && !any_inv && !any_clean;
    assign st_idx        = first_idx(store_vec_reg);
    assign store_rest    = store_vec_reg & ~(SLOTS'(1) << st_idx);
    assign can_emit      = !out_valid_reg || m_ready;
    assign is_known      = known_bits_reg[cmd_reg.guest];

    always_comb begin
        if (!is_known) begin
            load_action = ACT_LOAD;
            load_value  = '0;
        end else begin
            load_action = (rd_data_reg <= SMALL_IMM_MAX) ? ACT_IMM_LOW : ACT_IMM_FULL;
            load_value  = rd_data_reg;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (can_emit) begin
                    if (cmd_reg.op == OP_FLUSH_ALL || cmd_reg.op == OP_FLUSH_DISCARD) begin
                        state_next = ST_FLUSH;
                    end else if ((cmd_reg.op == OP_READ || cmd_reg.op == OP_WRITE)
                                 && need_evict) begin
                        state_next = ST_FILL;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FILL: begin
                if (can_emit) begin
                    state_next = ST_IDLE;
                end
            end
            ST_FLUSH: begin
                if (can_emit && (store_vec_reg == '0 || store_rest == '0)) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        q_pop       = 1'b0;
        emit        = 1'b0;
        e_action    = ACT_NONE;
        e_host      = '0;
        e_guest     = '0;
        e_value     = '0;
        e_known     = 1'b0;
        e_last      = 1'b1;
        fill_en     = 1'b0;
        fill_slot   = choose_idx;
        fill_dirty  = 1'b0;
        mark_en     = 1'b0;
        clean_en    = 1'b0;
        set_known   = 1'b0;
        clr_known   = 1'b0;
        mem_we      = 1'b0;
        reset_all   = 1'b0;
        flush_start = 1'b0;
        store_clr   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                q_pop = q_valid;
            end
            ST_EXEC: begin
                if (can_emit) begin
                    unique case (cmd_reg.op)
                        OP_READ, OP_WRITE: begin
                            clr_known = (cmd_reg.op == OP_WRITE);
                            if (need_evict) begin
                                emit     = 1'b1;
                                e_action = ACT_STORE;
                                e_host   = host_of('0);
                                e_guest  = slot_guest_reg[0];
                                e_last   = 1'b0;
                            end else if (hit) begin
                                emit    = 1'b1;
                                e_host  = host_of(hit_idx);
                                e_guest = cmd_reg.guest;
                                mark_en = (cmd_reg.op == OP_WRITE);
                            end else begin
                                emit       = 1'b1;
                                fill_en    = 1'b1;
                                fill_dirty = (cmd_reg.op == OP_WRITE);
                                e_host     = host_of(choose_idx);
                                e_guest    = cmd_reg.guest;
                                if (cmd_reg.op == OP_READ) begin
                                    e_action = load_action;
                                    e_value  = load_value;
                                end
                            end
                        end
                        OP_SET_IMM: begin
                            emit      = 1'b1;
                            e_guest   = cmd_reg.guest;
                            set_known = 1'b1;
                            mem_we    = 1'b1;
                        end
                        OP_QUERY: begin
                            emit    = 1'b1;
                            e_guest = cmd_reg.guest;
                            e_known = is_known;
                            e_value = is_known ? rd_data_reg : '0;
                        end
                        OP_FLUSH_ALL, OP_FLUSH_DISCARD: begin
                            flush_start = 1'b1;
                        end
                        OP_FLUSH_ONE: begin
                            emit = 1'b1;
                            if (|dirty_hit_vec) begin
                                e_action = ACT_STORE;
                                e_host   = host_of(dirty_hit_idx);
                                e_guest  = cmd_reg.guest;
                                clean_en = 1'b1;
                            end
                        end
                        default: begin
                            emit      = 1'b1;
                            reset_all = 1'b1;
                        end
                    endcase
                end
            end
            ST_FILL: begin
                if (can_emit) begin
                    emit       = 1'b1;
                    fill_en    = 1'b1;
                    fill_slot  = '0;
                    fill_dirty = (cmd_reg.op == OP_WRITE);
                    e_host     = host_of('0);
                    e_guest    = cmd_reg.guest;
                    if (cmd_reg.op == OP_READ) begin
                        e_action = load_action;
                        e_value  = load_value;
                    end
                end
            end
            ST_FLUSH: begin
                if (can_emit) begin
                    emit = 1'b1;
                    if (store_vec_reg != '0) begin
                        e_action  = ACT_STORE;
                        e_host    = host_of(st_idx);
                        e_guest   = slot_guest_reg[st_idx];
                        e_last    = (store_rest == '0);
                        store_clr = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cmd_reg     <= q_head;
            rd_data_reg <= known_mem[q_head.guest];
        end
        if (mem_we) begin
            known_mem[cmd_reg.guest] <= cmd_reg.value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                slot_guest_reg[i] <= '0;
            end
            slot_valid_reg <= '0;
            slot_dirty_reg <= '0;
            store_vec_reg  <= '0;
            known_bits_reg <= '0;
        end else begin
            if (reset_all) begin
                slot_valid_reg <= '0;
                slot_dirty_reg <= '0;
                known_bits_reg <= '0;
            end
            if (set_known) begin
                known_bits_reg[cmd_reg.guest] <= 1'b1;
            end
            if (clr_known) begin
                known_bits_reg[cmd_reg.guest] <= 1'b0;
            end
            if (fill_en) begin
                slot_guest_reg[fill_slot] <= cmd_reg.guest;
                slot_valid_reg[fill_slot] <= 1'b1;
                slot_dirty_reg[fill_slot] <= fill_dirty;
            end
            if (mark_en) begin
                slot_dirty_reg[hit_idx] <= 1'b1;
            end
            if (clean_en) begin
                slot_dirty_reg[dirty_hit_idx] <= 1'b0;
            end
            if (flush_start) begin
                slot_dirty_reg <= slot_dirty_reg & ~slot_valid_reg;
                store_vec_reg  <= flush_vec;
            end
            if (store_clr) begin
                store_vec_reg[st_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_action_reg <= e_action;
            out_host_reg   <= e_host;
            out_guest_reg  <= e_guest;
            out_value_reg  <= e_value;
            out_known_reg  <= e_known;
            out_last_reg   <= e_last;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_action        = out_action_reg;
    assign m_host_reg      = out_host_reg;
    assign m_guest_reg_out = out_guest_reg;
    assign m_value_out     = out_value_reg;
    assign m_known         = out_known_reg;
    assign m_last          = out_last_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(hit_vec))
        else $error("guest register cached in more than one slot");

    assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> (!out_valid_reg || m_ready))
        else $error("result overwrites a pending result");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (store_vec_reg & ~slot_valid_reg) == '0)
        else $error("pending store on an invalid slot");

    assert property (@(posedge aclk) disable iff (!aresetn)
        reset_all |=> (slot_valid_reg == '0 && known_bits_reg == '0))
        else $error("cache reset request left state behind");

endmodule
